FILE: rtl/rca_pkg.sv
// ============================================================================
// rca_pkg
// Shared widths, register indexes and the square-root digit step of the
// rounded corner alpha mask pipeline.
// ============================================================================
package rca_pkg;

    localparam int COORD_W     = 8;
    localparam int SEL_W       = 2;
    localparam int LEVEL_W     = 8;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd4;

    // doubled half-pixel offset, its square and the sum of two squares
    localparam int HALF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * HALF_W;
    localparam int SUM_W       = SQ_W + 1;

    // square root of sum << 14 gives the distance with 8 fraction bits
    localparam int SQ_FRAC_SHIFT = 14;
    localparam int SQ_OPND_W     = 34;
    localparam int SQ_DIGITS     = SQ_OPND_W / 2;
    localparam int SQ_ROOT_W     = SQ_DIGITS;
    localparam int SQ_REM_W      = SQ_ROOT_W + 2;
    localparam int SQ_PER_STAGE  = 3;
    localparam int SQ_STAGES     = (SQ_DIGITS + SQ_PER_STAGE - 1) / SQ_PER_STAGE;

    localparam int DIST_W      = SQ_ROOT_W;
    localparam int FACTOR_W    = 9;
    localparam int PROD_W      = LEVEL_W + FACTOR_W;

    localparam logic [FACTOR_W-1:0] FACTOR_FULL = 9'd256;
    localparam logic [DIST_W-1:0]   HALF_PIXEL  = 17'd128;

    typedef struct packed {
        logic               tile;
        logic [COORD_W-1:0] rad;
    } rca_side_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } sq_digit_t;

    // one restoring square-root digit: bring down two bits, try 4*root+1
    function automatic sq_digit_t sq_step(input sq_digit_t cur, input logic [1:0] pair);
        logic [SQ_REM_W+1:0] rem_sh;
        logic [SQ_REM_W+1:0] trial;
        sq_digit_t           nxt;
        rem_sh = {cur.rem, pair};
        trial  = {2'b00, cur.root, 2'b01};
        if (rem_sh >= trial)
        begin
            nxt.rem  = SQ_REM_W'(rem_sh - trial);
            nxt.root = {cur.root[SQ_ROOT_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = rem_sh[SQ_REM_W-1:0];
            nxt.root = {cur.root[SQ_ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

FILE: rtl/rca_front.sv
// ============================================================================
// rca_front
// Tile check, corner mirroring and the sum of squared half-pixel offsets,
// three register stages.
// ============================================================================
module rca_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rca_pkg::COORD_W-1:0] col,
    input  logic [rca_pkg::COORD_W-1:0] row,
    input  logic [rca_pkg::SEL_W-1:0]   sel,
    input  logic [rca_pkg::COORD_W-1:0] rad,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rca_pkg::SUM_W-1:0]   out_sum,
    output rca_pkg::rca_side_t          out_side
);
    import rca_pkg::*;

    logic              v1_reg, v2_reg, v3_reg;
    logic              rdy1, rdy2, rdy3;
    logic [HALF_W-1:0] hx_reg, hy_reg, hx_next, hy_next;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg;
    logic [SUM_W-1:0]  sum_reg;
    rca_side_t         side1_reg, side2_reg, side3_reg, side1_next;
    logic [COORD_W-1:0] dx, dy;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // mirrored offset 2*(R-x)-1 of a flipped column is simply 2*x+1
    always_comb
    begin
        dx              = rad - col;
        dy              = rad - row;
        hx_next         = sel[0] ? {col, 1'b1} : ({dx, 1'b0} - HALF_W'(1));
        hy_next         = sel[1] ? {row, 1'b1} : ({dy, 1'b0} - HALF_W'(1));
        side1_next.tile = (rad != '0) && (col < rad) && (row < rad);
        side1_next.rad  = rad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            hx_reg    <= hx_next;
            hy_reg    <= hy_next;
            side1_reg <= side1_next;
        end
        if (rdy2 && v1_reg)
        begin
            sqx_reg   <= SQ_W'(hx_reg) * SQ_W'(hx_reg);
            sqy_reg   <= SQ_W'(hy_reg) * SQ_W'(hy_reg);
            side2_reg <= side1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            sum_reg   <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_sum   = sum_reg;
    assign out_side  = side3_reg;

endmodule

FILE: rtl/rca_sqrt.sv
// ============================================================================
// rca_sqrt
// Pipelined restoring square root of (sum << 14), a few digits per stage.
// ============================================================================
module rca_sqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rca_pkg::SUM_W-1:0]     in_sum,
    input  rca_pkg::rca_side_t            in_side,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rca_pkg::SQ_ROOT_W-1:0] out_root,
    output rca_pkg::rca_side_t            out_side
);
    import rca_pkg::*;

    localparam int LAST = SQ_STAGES - 1;

    logic [SQ_STAGES-1:0] vld_reg;
    logic [SQ_STAGES-1:0] rdy;
    sq_digit_t            dig_reg  [SQ_STAGES];
    logic [SQ_OPND_W-1:0] opnd_reg [SQ_STAGES];
    rca_side_t            side_reg [SQ_STAGES];

    genvar s;
    generate
        for (s = 0; s < SQ_STAGES; s++)
        begin : g_stage
            logic                 vld_in;
            sq_digit_t            dig_in;
            logic [SQ_OPND_W-1:0] opnd_in;
            rca_side_t            side_in;
            sq_digit_t            dig_next;
            logic [SQ_OPND_W-1:0] opnd_next;

            if (s == 0)
            begin : g_first
                assign vld_in   = in_valid;
                assign dig_in   = '0;
                assign opnd_in  = {{(SQ_OPND_W - SUM_W - SQ_FRAC_SHIFT){1'b0}}, in_sum,
                                   {SQ_FRAC_SHIFT{1'b0}}};
                assign side_in  = in_side;
                assign in_ready = rdy[0];
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[s-1];
                assign dig_in  = dig_reg[s-1];
                assign opnd_in = opnd_reg[s-1];
                assign side_in = side_reg[s-1];
            end

            if (s == LAST)
            begin : g_tail
                assign rdy[s] = !vld_reg[s] || out_ready;
            end
            else
            begin : g_body
                assign rdy[s] = !vld_reg[s] || rdy[s+1];
            end

            // the last stage may hold fewer digits than the others
            always_comb
            begin
                dig_next  = dig_in;
                opnd_next = opnd_in;
                for (int k = 0; k < SQ_PER_STAGE; k++)
                begin
                    if (s * SQ_PER_STAGE + k < SQ_DIGITS)
                    begin
                        dig_next  = sq_step(dig_next, opnd_next[SQ_OPND_W-1 -: 2]);
                        opnd_next = {opnd_next[SQ_OPND_W-3:0], 2'b00};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[s] <= 1'b0;
                else if (rdy[s])
                    vld_reg[s] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s] && vld_in)
                begin
                    dig_reg[s]  <= dig_next;
                    opnd_reg[s] <= opnd_next;
                    side_reg[s] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[LAST];
    assign out_root  = dig_reg[LAST].root;
    assign out_side  = side_reg[LAST];

endmodule

FILE: rtl/rca_shade.sv
// ============================================================================
// rca_shade
// Edge ramp factor from the Q8 distance and the final BGRA output register.
// ============================================================================
module rca_shade
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rca_pkg::DIST_W-1:0]   in_dist,
    input  rca_pkg::rca_side_t           in_side,
    input  logic [rca_pkg::LEVEL_W-1:0]  red_level,
    input  logic [rca_pkg::LEVEL_W-1:0]  green_level,
    input  logic [rca_pkg::LEVEL_W-1:0]  blue_level,
    input  logic [rca_pkg::LEVEL_W-1:0]  alpha_level,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rca_pkg::LEVEL_W-1:0]  out_blue,
    output logic [rca_pkg::LEVEL_W-1:0]  out_green,
    output logic [rca_pkg::LEVEL_W-1:0]  out_red,
    output logic [rca_pkg::LEVEL_W-1:0]  out_alpha,
    output logic                        out_pixel_valid
);
    import rca_pkg::*;

    logic                v1_reg, v2_reg, rdy1, rdy2;
    logic                tile_reg;
    logic [FACTOR_W-1:0] factor_reg, factor_next;
    logic [DIST_W-1:0]   center, lo, hi, ramp;
    logic [PROD_W-1:0]   prod;
    logic [LEVEL_W-1:0]  blue_reg, green_reg, red_reg, alpha_reg;
    logic                pix_valid_reg;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // ramp spans radius minus half a pixel to radius plus half a pixel
    always_comb
    begin
        center = {1'b0, in_side.rad, 8'h00};
        lo     = center - HALF_PIXEL;
        hi     = center + HALF_PIXEL;
        ramp   = in_dist - lo;
        if (in_dist > hi)
            factor_next = FACTOR_FULL;
        else if (in_dist > lo)
            factor_next = ramp[FACTOR_W-1:0];
        else
            factor_next = '0;
    end

    assign prod = PROD_W'(alpha_level) * PROD_W'(factor_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            factor_reg <= factor_next;
            tile_reg   <= in_side.tile;
        end
        if (rdy2 && v1_reg)
        begin
            // drop the color for pixels off the tile
            blue_reg      <= tile_reg ? blue_level  : '0;
            green_reg     <= tile_reg ? green_level : '0;
            red_reg       <= tile_reg ? red_level   : '0;
            alpha_reg     <= tile_reg ? prod[PROD_W-2 -: LEVEL_W] : '0;
            pix_valid_reg <= tile_reg;
        end
    end

    assign out_valid       = v2_reg;
    assign out_blue        = blue_reg;
    assign out_green       = green_reg;
    assign out_red         = red_reg;
    assign out_alpha       = alpha_reg;
    assign out_pixel_valid = pix_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n) v1_reg |-> factor_reg <= FACTOR_FULL)
        else $error("edge factor above full scale");
    assert property (@(posedge clk) disable iff (!rst_n)
                     out_valid && !out_pixel_valid |-> out_alpha == '0)
        else $error("alpha on a pixel off the tile");
    assert property (@(posedge clk) disable iff (!rst_n) !in_ready |-> out_valid && !out_ready)
        else $error("shading input stalled while a stage is free");

endmodule

FILE: rtl/rounded_corner_alpha_mask_core.sv
// ============================================================================
// rounded_corner_alpha_mask_core
// Antialiased rounded corner overlay: one BGRA pixel per tile coordinate.
// ============================================================================
//  channel  dir  payload (low bit first)
//  s_       in   tdata: pixel_col[7:0], pixel_row[15:8]; tuser: corner_sel[1:0]
//  m_       out  tdata: out_blue, out_green, out_red, out_alpha; tuser: pixel_valid
//  cfg_     in   cfg_index 0..4, cfg_wdata 8 bits, taken when cfg_wr_en is high
//
//  One beat per clock sustained while m_tready stays high. Each beat passes
//  through the 17-digit square root, three digits per stage over six
//  stages, behind three front stages and two shading stages.
//  Reset clears the stage valid bits and loads the register reset values.
//  A full stage holds while its successor holds; empty stages fill up, so
//  s_tready falls only when all stages are full and m_tready is low.
// ============================================================================
module rounded_corner_alpha_mask_core
#(
    parameter int MAX_RADIUS = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pixel_col[7:0], pixel_row[15:8]
    input  logic [1:0]  s_tuser,   // corner_sel[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_blue, out_green, out_red, out_alpha
    output logic [0:0]  m_tuser,   // pixel_valid
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import rca_pkg::*;

    localparam logic [9:0] RAD_LIMIT = 10'(MAX_RADIUS);

    logic [LEVEL_W-1:0] radius_reg, red_reg, green_reg, blue_reg, alpha_reg;
    logic [COORD_W-1:0] rad_sat;

    logic                 fr_valid, fr_ready;
    logic [SUM_W-1:0]     fr_sum;
    rca_side_t            fr_side;
    logic                 sq_valid, sq_ready;
    logic [SQ_ROOT_W-1:0] sq_root;
    rca_side_t            sq_side;
    logic [LEVEL_W-1:0]   o_blue, o_green, o_red, o_alpha;
    logic                 o_pix_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            red_reg    <= '0;
            green_reg  <= '0;
            blue_reg   <= '0;
            alpha_reg  <= 8'hFF;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_wdata;
                REG_RED:    red_reg    <= cfg_wdata;
                REG_GREEN:  green_reg  <= cfg_wdata;
                REG_BLUE:   blue_reg   <= cfg_wdata;
                REG_ALPHA:  alpha_reg  <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    assign rad_sat = ({2'b00, radius_reg} > RAD_LIMIT) ? RAD_LIMIT[COORD_W-1:0] : radius_reg;

    rca_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .col       (s_tdata[7:0]),
        .row       (s_tdata[15:8]),
        .sel       (s_tuser),
        .rad       (rad_sat),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_sum   (fr_sum),
        .out_side  (fr_side)
    );

    rca_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_sum    (fr_sum),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    rca_shade u_shade
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (sq_valid),
        .in_ready        (sq_ready),
        .in_dist         (sq_root),
        .in_side         (sq_side),
        .red_level       (red_reg),
        .green_level     (green_reg),
        .blue_level      (blue_reg),
        .alpha_level     (alpha_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_blue        (o_blue),
        .out_green       (o_green),
        .out_red         (o_red),
        .out_alpha       (o_alpha),
        .out_pixel_valid (o_pix_valid)
    );

    assign m_tdata = {o_alpha, o_red, o_green, o_blue};
    assign m_tuser = o_pix_valid;

    assert property (@(posedge clk) disable iff (!rst_n)
                     m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("pixel off the tile carries nonzero color");
    assert property (@(posedge clk) disable iff (!rst_n) !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while the pipeline has a free stage");
    assert property (@(posedge clk) disable iff (!rst_n)
                     m_tvalid && m_tuser[0] |-> m_tdata[31:24] <= alpha_reg)
        else $error("alpha above the configured opacity");

endmodule
